>>> rtl/stbs_pkg.sv
// Shared types and constants for the sorted table binary search block.
package stbs_pkg;

    localparam int TABLE_DEPTH = 4096;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = ADDR_W + 1;
    localparam int KEY_W       = 64;
    localparam int ENTRY_W     = KEY_W + 1;
    localparam int S_DATA_W    = ((ADDR_W + ENTRY_W + 7) / 8) * 8;
    localparam int M_DATA_W    = ((ADDR_W + 7) / 8) * 8;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PROBE,
        ST_CMP,
        ST_DONE
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic accept_write;
        logic accept_search;
        logic probe;
        logic step;
        logic finish;
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic range_open;
        logic hit;
        logic out_free;
    } stat_t;

endpackage

>>> rtl/stbs_ctrl.sv
// Controller state machine for the table search.
module stbs_ctrl import stbs_pkg::*; (
    input  logic   aclk,
    input  logic   aresetn,
    input  logic   s_tvalid,
    input  logic   s_mode,
    output logic   s_tready,
    input  stat_t  stat,
    output cmd_t   cmd
);

    state_t state_reg, state_next;

    // Hold state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid && s_mode) state_next = ST_PROBE;
            end
            ST_PROBE: begin
                state_next = stat.range_open ? ST_CMP : ST_DONE;
            end
            ST_CMP: begin
                state_next = stat.hit ? ST_DONE : ST_PROBE;
            end
            ST_DONE: begin
                if (stat.out_free) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Outputs
    always_comb begin
        s_tready = 1'b0;
        cmd      = '0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready          = 1'b1;
                cmd.accept_write  = s_tvalid && !s_mode;
                cmd.accept_search = s_tvalid && s_mode;
            end
            ST_PROBE: begin
                cmd.probe = stat.range_open;
            end
            ST_CMP: begin
                cmd.step = 1'b1;
            end
            ST_DONE: begin
                cmd.finish = stat.out_free;
            end
            default: ;
        endcase
    end

endmodule

>>> rtl/stbs_dp.sv
// Datapath: entry memory, search bounds, compare and result register.
module stbs_dp import stbs_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic [CNT_W-1:0]     cfg_wdata,
    input  logic                 cfg_we,
    input  logic [ADDR_W-1:0]    in_index,
    input  logic                 in_side,
    input  logic [KEY_W-1:0]     in_key,
    input  cmd_t                 cmd,
    output stat_t                stat,
    input  logic                 m_tready,
    output logic                 m_tvalid,
    output logic                 out_found,
    output logic [ADDR_W-1:0]    out_index
);

    logic [ENTRY_W-1:0] mem [TABLE_DEPTH];
    logic [ENTRY_W-1:0] rd_data_reg;

    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   lo_reg, hi_reg;
    logic [ADDR_W-1:0]  mid_reg;
    logic [ENTRY_W-1:0] probe_reg;
    logic               res_found_reg;
    logic [ADDR_W-1:0]  res_index_reg;
    logic               out_valid_reg;
    logic               out_found_reg;
    logic [ADDR_W-1:0]  out_index_reg;

    logic [CNT_W-1:0]   count_sat;
    logic [CNT_W-1:0]   mid;
    logic               item_greater;
    logic               item_equal;

    // Saturate count to the table depth
    assign count_sat = (count_reg > CNT_W'(TABLE_DEPTH)) ? CNT_W'(TABLE_DEPTH) : count_reg;

    // Midpoint of the open range
    assign mid = lo_reg + ((hi_reg - lo_reg) >> 1);

    // Side is the top bit, so one unsigned compare orders side then key
    assign item_equal   = (probe_reg == rd_data_reg);
    assign item_greater = (probe_reg > rd_data_reg);

    assign stat.range_open = (lo_reg < hi_reg);
    assign stat.hit        = item_equal;
    assign stat.out_free   = !out_valid_reg || m_tready;

    // Config register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else if (cfg_we) begin
            count_reg <= cfg_wdata;
        end
    end

    // Entry memory: write on a write request, registered read on a probe
    always_ff @(posedge aclk) begin
        if (cmd.accept_write) begin
            mem[in_index] <= {in_side, in_key};
        end
        if (cmd.probe) begin
            rd_data_reg <= mem[mid[ADDR_W-1:0]];
        end
    end

    // Search bounds and running result
    always_ff @(posedge aclk) begin
        if (cmd.accept_search) begin
            lo_reg        <= '0;
            hi_reg        <= count_sat;
            probe_reg     <= {in_side, in_key};
            res_found_reg <= 1'b0;
            res_index_reg <= '0;
        end
        if (cmd.probe) begin
            mid_reg <= mid[ADDR_W-1:0];
        end
        if (cmd.step) begin
            if (item_equal) begin
                res_found_reg <= 1'b1;
                res_index_reg <= mid_reg;
            end else if (item_greater) begin
                lo_reg <= {1'b0, mid_reg} + CNT_W'(1);
            end else begin
                hi_reg <= {1'b0, mid_reg};
            end
        end
    end

    // Output register: load on finish, drop when taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.finish) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.finish) begin
            out_found_reg <= res_found_reg;
            out_index_reg <= res_index_reg;
        end
    end

    assign m_tvalid  = out_valid_reg;
    assign out_found = out_found_reg;
    assign out_index = out_index_reg;

endmodule

>>> rtl/sorted_table_binary_search.sv
// Top level of the sorted table binary search block.
//
//  channel  dir  tdata (low bit up)                         tuser
//  s_       in   entry_index[11:0] side[12] key[76:13] pad  mode (0 write, 1 search)
//  m_       out  match_index[11:0] pad[15:12]                found
//  cfg_     in   cfg_wdata = entry_count[12:0], taken when cfg_we is high
//
// A write request is stored in the entry memory as it is taken. A search makes
// at most 13 probes of the entry memory for 4096 entries, each a registered read
// then the 65-bit compare, before the result is registered.
// The result register lets the next request in while a result waits.
// Reset is synchronous on aresetn low; it clears control and entry_count,
// the entry memory is not cleared.
module sorted_table_binary_search import stbs_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_we,
    input  logic [CNT_W-1:0]     cfg_wdata,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_DATA_W-1:0]  s_tdata,   // entry_index, side, search_key, zero pad
    input  logic                 s_tuser,   // mode
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_DATA_W-1:0]  m_tdata,   // match_index, zero pad
    output logic                 m_tuser    // found
);

    cmd_t              cmd;
    stat_t             stat;
    logic [ADDR_W-1:0] out_index;

    stbs_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_mode   (s_tuser),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    stbs_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wdata (cfg_wdata),
        .cfg_we    (cfg_we),
        .in_index  (s_tdata[ADDR_W-1:0]),
        .in_side   (s_tdata[ADDR_W]),
        .in_key    (s_tdata[ADDR_W+KEY_W:ADDR_W+1]),
        .cmd       (cmd),
        .stat      (stat),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .out_found (m_tuser),
        .out_index (out_index)
    );

    assign m_tdata = {{(M_DATA_W-ADDR_W){1'b0}}, out_index};

endmodule

>>> rtl/stbs_checker.sv
// Port-level checks for the sorted table binary search block, bound to the top.
module stbs_checker import stbs_pkg::*; (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_tvalid,
    input logic                s_tready,
    input logic                s_tuser,
    input logic                m_tvalid,
    input logic                m_tready,
    input logic [M_DATA_W-1:0] m_tdata,
    input logic                m_tuser
);

    // A stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // A miss reports index zero
    a_miss_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> m_tdata == '0)
        else $error("miss with nonzero index");

    // Pad bits stay zero
    a_pad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[M_DATA_W-1:ADDR_W] == '0)
        else $error("result pad bits set");

    // A search blocks new requests in the next cycle
    a_search_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tuser |=> !s_tready)
        else $error("request taken during search");

    // No result can appear the cycle after a search request
    a_no_instant: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tuser && !m_tvalid |=> !m_tvalid)
        else $error("result appeared too early");

endmodule

bind sorted_table_binary_search stbs_checker u_stbs_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
